// ===== rtl/core/atsp_pkg.sv =====
`default_nettype none
package atsp_pkg;

  typedef enum logic [1:0] {
    PH_GROUND = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_READ,
    CMD_CR,
    CMD_LF,
    CMD_PRINT,
    CMD_FINAL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ERASE,
    ST_EMIT
  } eng_state_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic [4:0] row;
    logic [7:0] col;
    logic [7:0] p1;
    logic [7:0] p2;
    phase_t     phase;
  } cmd_t;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PMAX  = 8'h3f;
  localparam logic [7:0] CH_IMAX  = 8'h2f;
  localparam logic [7:0] CH_FMIN  = 8'h40;
  localparam logic [7:0] CH_FMAX  = 8'h7e;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] FIN_J    = 8'h4a;
  localparam logic [7:0] FIN_H    = 8'h48;
  localparam logic [7:0] FIN_F    = 8'h66;
  localparam logic [7:0] FIN_A    = 8'h41;
  localparam logic [7:0] FIN_B    = 8'h42;
  localparam logic [7:0] FIN_C    = 8'h43;
  localparam logic [7:0] FIN_D    = 8'h44;
  localparam logic [7:0] FIN_K    = 8'h4b;

endpackage
`default_nettype wire

// ===== rtl/core/atsp_front.sv =====
`default_nettype none
module atsp_front #(
  parameter int PARAM_BYTES_MAX = 63
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_operation,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic [4:0]    in_read_row,
  input  wire logic [7:0]    in_read_col,
  output logic               cmd_valid,
  output atsp_pkg::cmd_t     cmd,
  input  wire logic          cmd_pop
);
  import atsp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [2:0] tok_idx_r, tok_idx_nxt;
  logic [1:0] tok_flags_r, tok_flags_nxt;
  logic [5:0] count_r, count_nxt;
  cmd_t       new_cmd;
  logic [11:0] acc;
  logic [7:0]  c;

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       push_ok;

  assign push_ok   = in_push && !in_full;
  assign in_full   = (fill_r == 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign c         = in_data_byte;

  always_comb begin
    phase_nxt     = phase_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    tok_idx_nxt   = tok_idx_r;
    tok_flags_nxt = tok_flags_r;
    count_nxt     = count_r;
    acc           = '0;
    new_cmd.kind  = CMD_NOP;
    new_cmd.ch    = c;
    new_cmd.row   = in_read_row;
    new_cmd.col   = in_read_col;
    if (in_operation) begin
      new_cmd.kind = CMD_READ;
    end else begin
      unique case (phase_r)
        PH_ESC: begin
          if (c == CH_LBRK) begin
            phase_nxt     = PH_CSI;
            p1_nxt        = '0;
            p2_nxt        = '0;
            tok_idx_nxt   = '0;
            tok_flags_nxt = '0;
            count_nxt     = '0;
          end else begin
            phase_nxt = PH_GROUND;
          end
        end
        PH_CSI: begin
          priority if (c >= CH_ZERO && c <= CH_PMAX) begin
            if (count_r < 6'(PARAM_BYTES_MAX)) begin
              count_nxt = count_r + 6'd1;
              if (c == CH_SEMI) begin
                if (tok_flags_r[0] && tok_idx_r < 3'd4) tok_idx_nxt = tok_idx_r + 3'd1;
                tok_flags_nxt = '0;
              end else begin
                // a fresh token starts accumulating digits
                tok_flags_nxt = tok_flags_r[0] ? tok_flags_r : 2'd3;
                if (tok_flags_nxt[1]) begin
                  if (c <= CH_NINE) begin
                    if (tok_idx_r == 3'd0) begin
                      acc = 12'(p1_r) * 12'd10 + 12'(c - CH_ZERO);
                      p1_nxt = (acc > 12'd255) ? 8'd255 : acc[7:0];
                    end else if (tok_idx_r == 3'd1) begin
                      acc = 12'(p2_r) * 12'd10 + 12'(c - CH_ZERO);
                      p2_nxt = (acc > 12'd255) ? 8'd255 : acc[7:0];
                    end
                  end else begin
                    tok_flags_nxt = 2'd1;
                  end
                end
              end
            end
          end else if (c >= CH_SPACE && c <= CH_IMAX) begin
          end else if (c >= CH_FMIN && c <= CH_FMAX) begin
            new_cmd.kind = CMD_FINAL;
            phase_nxt    = PH_GROUND;
          end else begin
            phase_nxt = PH_GROUND;
          end
        end
        default: begin
          phase_nxt = PH_GROUND;
          priority if (c == CH_ESC) phase_nxt = PH_ESC;
          else if (c == CH_CR) new_cmd.kind = CMD_CR;
          else if (c == CH_LF) new_cmd.kind = CMD_LF;
          else if ((c >= CH_SPACE && c < CH_DEL) || c >= CH_HIGH) new_cmd.kind = CMD_PRINT;
          else new_cmd.kind = CMD_NOP;
        end
      endcase
    end
    new_cmd.p1    = p1_r;
    new_cmd.p2    = p2_r;
    new_cmd.phase = in_operation ? phase_r : phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_GROUND;
      p1_r        <= '0;
      p2_r        <= '0;
      tok_idx_r   <= '0;
      tok_flags_r <= '0;
      count_r     <= '0;
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      fill_r      <= '0;
    end else begin
      if (push_ok) begin
        phase_r     <= phase_nxt;
        p1_r        <= p1_nxt;
        p2_r        <= p2_nxt;
        tok_idx_r   <= tok_idx_nxt;
        tok_flags_r <= tok_flags_nxt;
        count_r     <= count_nxt;
        wr_ptr_r    <= ~wr_ptr_r;
      end
      if (cmd_pop && cmd_valid) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + 2'(push_ok) - 2'(cmd_pop && cmd_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_ptr_r] <= new_cmd;
  end

endmodule
`default_nettype wire

// ===== rtl/core/atsp_back.sv =====
`default_nettype none
module atsp_back #(
  parameter int SCREEN_ROWS = 24,
  parameter int SCREEN_COLS = 80,
  parameter int ROW_STORE   = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  atsp_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [7:0]         out_cell_char,
  output logic [7:0]         out_line_length,
  output logic [4:0]         out_cursor_row,
  output logic [7:0]         out_cursor_col,
  output logic [1:0]         out_parse_phase
);
  import atsp_pkg::*;

  localparam int DEPTH = SCREEN_ROWS * ROW_STORE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(SCREEN_ROWS);

  logic [7:0] cell_mem [DEPTH];
  logic [7:0] rd_data_r;
  logic [7:0] row_len_r [SCREEN_ROWS];

  eng_state_t state_r, state_nxt;
  logic [4:0] row_r, row_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       is_read_r, is_read_nxt;
  logic       hit_r, hit_nxt;
  logic [7:0] rlen_r, rlen_nxt;
  phase_t     ph_r, ph_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_addr, rd_addr;
  logic [7:0]    mem_wdata;
  logic          len_we, len_clr;
  logic [7:0]    len_wdata;
  logic [7:0]    cur_len, rd_len, n;
  logic [8:0]    sum;
  logic          out_valid_r, out_load;

  function automatic logic [AW-1:0] addr_of(input logic [4:0] r, input logic [7:0] cl);
    addr_of = AW'(r) * AW'(ROW_STORE) + AW'(cl);
  endfunction

  assign cur_len   = (32'(row_r) < SCREEN_ROWS) ? row_len_r[RW'(row_r)] : 8'd0;
  assign rd_len    = (32'(cmd.row) < SCREEN_ROWS) ? row_len_r[RW'(cmd.row)] : 8'd0;
  assign n         = (cmd.p1 != 8'd0) ? cmd.p1 : 8'd1;
  assign out_empty = !out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    pos_nxt     = pos_r;
    ch_nxt      = ch_r;
    is_read_nxt = is_read_r;
    hit_nxt     = hit_r;
    rlen_nxt    = rlen_r;
    ph_nxt      = ph_r;
    cmd_pop     = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = addr_of(row_r, pos_r);
    mem_wdata   = CH_SPACE;
    rd_addr     = addr_of(cmd.row, cmd.col);
    len_we      = 1'b0;
    len_clr     = 1'b0;
    len_wdata   = pos_r;
    out_load    = 1'b0;
    sum         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          is_read_nxt = 1'b0;
          ph_nxt      = cmd.phase;
          state_nxt   = ST_EMIT;
          unique case (cmd.kind)
            CMD_READ: begin
              is_read_nxt = 1'b1;
              rlen_nxt    = rd_len;
              hit_nxt     = cmd.col < rd_len;
            end
            CMD_CR: col_nxt = '0;
            CMD_LF: begin
              sum = 9'(row_r) + 9'd1;
              row_nxt = (32'(sum) >= SCREEN_ROWS) ? 5'(SCREEN_ROWS - 1) : sum[4:0];
            end
            CMD_PRINT: begin
              if (32'(row_r) < SCREEN_ROWS) begin
                if (col_r < cur_len) begin
                  mem_we    = 1'b1;
                  mem_addr  = addr_of(row_r, col_r);
                  mem_wdata = cmd.ch;
                  col_nxt   = (col_r != 8'd255) ? col_r + 8'd1 : col_r;
                end else begin
                  // pad the gap with spaces one cell a cycle
                  pos_nxt   = cur_len;
                  ch_nxt    = cmd.ch;
                  state_nxt = ST_PAD;
                end
              end
            end
            CMD_FINAL: begin
              unique case (cmd.ch)
                FIN_J: begin
                  len_clr = 1'b1;
                  row_nxt = '0;
                  col_nxt = '0;
                end
                FIN_H, FIN_F: begin
                  row_nxt = (cmd.p1 == 8'd0) ? 5'd0
                          : (32'(cmd.p1) > SCREEN_ROWS) ? 5'(SCREEN_ROWS - 1)
                          : 5'(cmd.p1 - 8'd1);
                  col_nxt = (cmd.p2 == 8'd0) ? 8'd0
                          : (32'(cmd.p2) > SCREEN_COLS) ? 8'(SCREEN_COLS - 1)
                          : cmd.p2 - 8'd1;
                end
                FIN_A: row_nxt = (8'(row_r) > n) ? 5'(8'(row_r) - n) : 5'd0;
                FIN_B: begin
                  sum = 9'(row_r) + 9'(n);
                  row_nxt = (32'(sum) >= SCREEN_ROWS) ? 5'(SCREEN_ROWS - 1) : sum[4:0];
                end
                FIN_C: begin
                  sum = 9'(col_r) + 9'(n);
                  col_nxt = (32'(sum) >= SCREEN_COLS) ? 8'(SCREEN_COLS - 1) : sum[7:0];
                end
                FIN_D: col_nxt = (col_r > n) ? col_r - n : 8'd0;
                FIN_K: begin
                  if (cmd.p1 == 8'd0 && 32'(row_r) < SCREEN_ROWS) begin
                    pos_nxt   = col_r;
                    state_nxt = ST_ERASE;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        if (pos_r < col_r && 32'(pos_r) < ROW_STORE - 2) begin
          mem_we  = 1'b1;
          pos_nxt = pos_r + 8'd1;
        end else begin
          len_we = 1'b1;
          if (32'(pos_r) < ROW_STORE - 1) begin
            mem_we    = 1'b1;
            mem_wdata = ch_r;
            len_wdata = pos_r + 8'd1;
          end
          col_nxt   = (col_r != 8'd255) ? col_r + 8'd1 : col_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_ERASE: begin
        if (pos_r < cur_len) begin
          mem_we  = 1'b1;
          pos_nxt = pos_r + 8'd1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SCREEN_ROWS; i++) row_len_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      if (len_clr) begin
        for (int i = 0; i < SCREEN_ROWS; i++) row_len_r[i] <= '0;
      end else if (len_we) begin
        row_len_r[RW'(row_r)] <= len_wdata;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    ch_r      <= ch_nxt;
    is_read_r <= is_read_nxt;
    hit_r     <= hit_nxt;
    rlen_r    <= rlen_nxt;
    ph_r      <= ph_nxt;
    if (out_load) begin
      out_cell_char   <= (is_read_r && hit_r) ? rd_data_r : 8'd0;
      out_line_length <= is_read_r ? rlen_r : 8'd0;
      out_cursor_row  <= row_r;
      out_cursor_col  <= col_r;
      out_parse_phase <= ph_r;
    end
  end

  // read data is held while the result waits for the output register
  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_addr] <= mem_wdata;
    if (state_r == ST_IDLE) rd_data_r <= cell_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ansi_terminal_screen_parser.sv =====
// a read or simple byte passes the command queue, the engine and the output register
// engine: each item passes the idle and emit states, and emit waits while the output register is full and not popped;
//   a padded write fills one space per cycle and then writes the byte, an erase-line blanks one cell per cycle
// the command queue holds two items, so the parser keeps accepting while the engine walks, until the queue is full
// reset: synchronous active-low rst_n clears cursor, parser, row lengths, the command queue and the output valid flag
`default_nettype none
module ansi_terminal_screen_parser #(
  parameter int SCREEN_ROWS     = 24,
  parameter int SCREEN_COLS     = 80,
  parameter int ROW_STORE       = 256,
  parameter int PARAM_BYTES_MAX = 63
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [4:0] in_read_row,
  input  wire logic [7:0] in_read_col,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_cell_char,
  output logic [7:0]      out_line_length,
  output logic [4:0]      out_cursor_row,
  output logic [7:0]      out_cursor_col,
  output logic [1:0]      out_parse_phase
);
  import atsp_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  atsp_front #(.PARAM_BYTES_MAX(PARAM_BYTES_MAX)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_operation, .in_data_byte,
    .in_read_row, .in_read_col, .cmd_valid, .cmd, .cmd_pop
  );

  atsp_back #(
    .SCREEN_ROWS(SCREEN_ROWS), .SCREEN_COLS(SCREEN_COLS), .ROW_STORE(ROW_STORE)
  ) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .out_empty, .out_pop,
    .out_cell_char, .out_line_length, .out_cursor_row, .out_cursor_col, .out_parse_phase
  );

endmodule
`default_nettype wire
